FILE: sv/gpi_pkg.sv
`default_nettype none
package gpi_pkg;
  localparam int MAX_ENTRIES = 64;
  localparam int GRID_CELLS = 1024;
  localparam int SLOT_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CELL_AW = $clog2(GRID_CELLS);

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_LOAD = 3'd1;
  localparam logic [2:0] OP_BUILD = 3'd2;
  localparam logic [2:0] OP_FIND_POS = 3'd3;
  localparam logic [2:0] OP_FIND_ID = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE = 3'd3;
  localparam logic [2:0] ST_COLLISION = 3'd4;
  localparam logic [2:0] ST_FULL = 3'd5;
endpackage
`default_nettype wire

FILE: sv/grid_position_index_unit.sv
// grid position index unit
// input channel: in_valid/in_stall carry op, entry_id, pos_x, pos_y; a transfer
// happens when in_valid is high and in_stall is low. in_stall stays high while
// an operation runs or while the result waits in the output register.
// output channel: out_valid/out_stall carry one result per operation.
// operations: clear, load, an empty build and unknown ops answer from the
// decode state; a position query ends at the box check outside the box, after
// the grid read on an empty cell and after the table read on a hit; an id
// query takes at most 7 halving steps, each a table read and a compare.
// a build walks the table once for the bounding box, multiplies w*h, and a
// plane too large ends there; it then sweeps the 1024-cell grid memory one
// cell a cycle and places each entry (one multiply, one grid read and write);
// a collision ends it after that entry's grid read and the table read of the
// entry already in the cell.
// one operation at a time: the next transfer is taken the cycle after the
// result transfers, at the earliest; all steps share a single multiplier and
// the table and grid memory ports.
// reset clears the count, the plane and the control state; the table and the
// grid need no clearing pass. a stalled result holds until it is taken.
`default_nettype none
module grid_position_index_unit import gpi_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        in_op,
  input  wire logic [15:0]       in_entry_id,
  input  wire logic signed [7:0] in_pos_x,
  input  wire logic signed [7:0] in_pos_y,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             out_status,
  output logic [5:0]             out_found_index,
  output logic [15:0]            out_found_id,
  output logic [15:0]            out_other_id,
  output logic signed [7:0]      out_origin_x,
  output logic signed [7:0]      out_origin_y,
  output logic [8:0]             out_span_w,
  output logic [8:0]             out_span_h
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_BOX_RD = 4'd2;
  localparam logic [3:0] S_BOX_UP = 4'd3;
  localparam logic [3:0] S_AREA   = 4'd4;
  localparam logic [3:0] S_CLR    = 4'd5;
  localparam logic [3:0] S_PL_RD  = 4'd6;
  localparam logic [3:0] S_PL_MUL = 4'd7;
  localparam logic [3:0] S_PL_CHK = 4'd8;
  localparam logic [3:0] S_PL_GR  = 4'd9;
  localparam logic [3:0] S_COL_RD = 4'd10;
  localparam logic [3:0] S_FP_MUL = 4'd11;
  localparam logic [3:0] S_FP_GR  = 4'd12;
  localparam logic [3:0] S_FP_ID  = 4'd13;
  localparam logic [3:0] S_FI_RD  = 4'd14;
  localparam logic [3:0] S_FI_CMP = 4'd15;

  logic [15:0] ids_m [MAX_ENTRIES];
  logic [7:0]  xs_m  [MAX_ENTRIES];
  logic [7:0]  ys_m  [MAX_ENTRIES];
  logic [SLOT_W:0] grid_m [GRID_CELLS];

  logic [3:0] state_r;
  logic [2:0] op_r;
  logic [15:0] id_r;
  logic signed [7:0] qx_r, qy_r;
  logic [CNT_W-1:0] count_r;
  logic signed [7:0] px_r, py_r;
  logic [8:0] pw_r, ph_r;
  logic valid_r;
  logic signed [7:0] xlo_r, xhi_r, ylo_r, yhi_r;
  logic [CNT_W-1:0] i_r, lo_r, hi_r;
  logic [CELL_AW:0] clr_r;
  logic [17:0] prod_r;
  logic [15:0] cur_id_r;

  // table read port
  logic [SLOT_W-1:0] t_addr;
  logic [15:0] t_id_q;
  logic signed [7:0] t_x_q, t_y_q;
  // grid port
  logic [CELL_AW-1:0] g_addr;
  logic [SLOT_W:0] g_q, g_wd;
  logic g_we;

  // shared multiplier
  logic [8:0] mul_a, mul_b;
  logic [17:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic [CNT_W-1:0] mid;
  assign mid = CNT_W'((lo_r + hi_r) >> 1);

  logic [8:0] dx, dy;
  always_comb begin
    mul_a = pw_r;
    mul_b = ph_r;
    dx = 9'(signed'({t_x_q[7], t_x_q}) - signed'({px_r[7], px_r}));
    dy = 9'(signed'({t_y_q[7], t_y_q}) - signed'({py_r[7], py_r}));
    if (state_r == S_FP_MUL) begin
      dx = 9'(signed'({qx_r[7], qx_r}) - signed'({px_r[7], px_r}));
      dy = 9'(signed'({qy_r[7], qy_r}) - signed'({py_r[7], py_r}));
    end
    if (state_r == S_PL_MUL || state_r == S_FP_MUL) begin
      mul_a = dy;
      mul_b = pw_r;
    end
  end

  logic [8:0] dxq_r;
  logic [18:0] cell_full;
  assign cell_full = {1'b0, prod_r} + {10'd0, dxq_r};

  always_comb begin
    t_addr = i_r[SLOT_W-1:0];
    if (state_r == S_FI_RD) t_addr = mid[SLOT_W-1:0];
    if (state_r == S_COL_RD || state_r == S_FP_ID) t_addr = SLOT_W'(g_q - 1'b1);
    g_addr = cell_full >= 19'(GRID_CELLS) ? '0 : cell_full[CELL_AW-1:0];
    if (state_r == S_CLR) g_addr = clr_r[CELL_AW-1:0];
    g_we = (state_r == S_CLR) || (state_r == S_PL_GR && g_q == '0);
    g_wd = (state_r == S_CLR) ? '0 : (SLOT_W+1)'({1'b0, i_r} + 1'b1);
  end

  logic load_we;
  assign load_we = state_r == S_DEC && op_r == OP_LOAD && count_r < CNT_W'(MAX_ENTRIES);

  always_ff @(posedge clk) begin
    if (load_we) begin
      ids_m[count_r[SLOT_W-1:0]] <= id_r;
      xs_m[count_r[SLOT_W-1:0]] <= qx_r;
      ys_m[count_r[SLOT_W-1:0]] <= qy_r;
    end
    t_id_q <= ids_m[t_addr];
    t_x_q <= xs_m[t_addr];
    t_y_q <= ys_m[t_addr];
  end

  always_ff @(posedge clk) begin
    if (g_we) grid_m[g_addr] <= g_wd;
    g_q <= grid_m[g_addr];
  end

  // whether the queried position lies inside the built plane (checked in S_FP_MUL)
  logic in_box;
  assign in_box = valid_r && qx_r >= px_r && qy_r >= py_r && dx < pw_r && dy < ph_r;

  task automatic emit(input logic [2:0] st, input logic [5:0] ix, input logic [15:0] fid,
                      input logic [15:0] oid);
    out_valid <= 1'b1;
    out_status <= st;
    out_found_index <= ix;
    out_found_id <= fid;
    out_other_id <= oid;
  endtask

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      count_r <= '0;
      px_r <= '0;
      py_r <= '0;
      pw_r <= '0;
      ph_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            op_r <= in_op;
            id_r <= in_entry_id;
            qx_r <= in_pos_x;
            qy_r <= in_pos_y;
            i_r <= '0;
            lo_r <= '0;
            hi_r <= count_r;
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          state_r <= S_IDLE;
          case (op_r)
            OP_CLEAR: begin
              count_r <= '0;
              px_r <= '0;
              py_r <= '0;
              pw_r <= '0;
              ph_r <= '0;
              valid_r <= 1'b0;
              emit(ST_OK, '0, '0, '0);
              out_origin_x <= '0;
              out_origin_y <= '0;
              out_span_w <= '0;
              out_span_h <= '0;
            end
            OP_LOAD: begin
              if (load_we) begin
                emit(ST_OK, 6'(count_r), id_r, '0);
                count_r <= count_r + 1'b1;
              end else begin
                emit(ST_FULL, '0, '0, '0);
              end
              out_origin_x <= px_r;
              out_origin_y <= py_r;
              out_span_w <= pw_r;
              out_span_h <= ph_r;
            end
            OP_BUILD: begin
              valid_r <= 1'b0;
              if (count_r == '0) begin
                px_r <= '0;
                py_r <= '0;
                pw_r <= '0;
                ph_r <= '0;
                emit(ST_EMPTY, '0, '0, '0);
                out_origin_x <= '0;
                out_origin_y <= '0;
                out_span_w <= '0;
                out_span_h <= '0;
              end else begin
                state_r <= S_BOX_RD;
              end
            end
            OP_FIND_POS: state_r <= S_FP_MUL;
            OP_FIND_ID: state_r <= S_FI_RD;
            default: begin
              emit(ST_NOT_FOUND, '0, '0, '0);
              out_origin_x <= px_r;
              out_origin_y <= py_r;
              out_span_w <= pw_r;
              out_span_h <= ph_r;
            end
          endcase
        end
        S_BOX_RD: state_r <= S_BOX_UP;
        S_BOX_UP: begin
          if (i_r == '0) begin
            xlo_r <= t_x_q;
            xhi_r <= t_x_q;
            ylo_r <= t_y_q;
            yhi_r <= t_y_q;
          end else begin
            if (t_x_q < xlo_r) xlo_r <= t_x_q;
            if (t_x_q > xhi_r) xhi_r <= t_x_q;
            if (t_y_q < ylo_r) ylo_r <= t_y_q;
            if (t_y_q > yhi_r) yhi_r <= t_y_q;
          end
          if (i_r + 1'b1 == count_r) begin
            state_r <= S_AREA;
            i_r <= '0;
          end else begin
            i_r <= i_r + 1'b1;
            state_r <= S_BOX_RD;
          end
        end
        S_AREA: begin
          px_r <= xlo_r;
          py_r <= ylo_r;
          pw_r <= 9'(signed'({xhi_r[7], xhi_r}) - signed'({xlo_r[7], xlo_r}) + 10'sd1);
          ph_r <= 9'(signed'({yhi_r[7], yhi_r}) - signed'({ylo_r[7], ylo_r}) + 10'sd1);
          clr_r <= '0;
          state_r <= S_CLR;
          if (i_r == '0) begin
            i_r <= CNT_W'(1);
            state_r <= S_AREA;
          end else begin
            i_r <= '0;
            if (mul_p > 18'(GRID_CELLS)) begin
              pw_r <= '0;
              ph_r <= '0;
              emit(ST_TOO_LARGE, '0, '0, '0);
              out_origin_x <= px_r;
              out_origin_y <= py_r;
              out_span_w <= '0;
              out_span_h <= '0;
              state_r <= S_IDLE;
            end
          end
        end
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (CELL_AW+1)'(GRID_CELLS - 1)) state_r <= S_PL_RD;
        end
        S_PL_RD: begin
          if (i_r == count_r) begin
            valid_r <= 1'b1;
            emit(ST_OK, '0, '0, '0);
            out_origin_x <= px_r;
            out_origin_y <= py_r;
            out_span_w <= pw_r;
            out_span_h <= ph_r;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_PL_MUL;
          end
        end
        S_PL_MUL: begin
          prod_r <= mul_p;
          dxq_r <= dx;
          cur_id_r <= t_id_q;
          state_r <= S_PL_CHK;
        end
        S_PL_CHK: state_r <= S_PL_GR;
        S_PL_GR: begin
          if (g_q != '0) begin
            state_r <= S_COL_RD;
          end else begin
            i_r <= i_r + 1'b1;
            state_r <= S_PL_RD;
          end
        end
        S_COL_RD: state_r <= 4'd0 | S_COL_RD;
        default: ;
      endcase
      if (state_r == S_COL_RD) begin
        if (clr_r[0]) begin
          emit(ST_COLLISION, 6'(i_r), cur_id_r, t_id_q);
          out_origin_x <= px_r;
          out_origin_y <= py_r;
          out_span_w <= pw_r;
          out_span_h <= ph_r;
          state_r <= S_IDLE;
        end
        clr_r[0] <= ~clr_r[0];
      end
      if (state_r == S_FP_MUL) begin
        prod_r <= mul_p;
        dxq_r <= dx;
        out_origin_x <= px_r;
        out_origin_y <= py_r;
        out_span_w <= pw_r;
        out_span_h <= ph_r;
        if (!in_box) begin
          emit(ST_NOT_FOUND, '0, '0, '0);
          state_r <= S_IDLE;
        end else begin
          clr_r[0] <= 1'b0;
          state_r <= S_FP_GR;
        end
      end
      if (state_r == S_FP_GR) begin
        clr_r[0] <= 1'b1;
        if (clr_r[0]) begin
          if (g_q == '0 || CNT_W'(g_q) > count_r) begin
            emit(ST_NOT_FOUND, '0, '0, '0);
            state_r <= S_IDLE;
          end else begin
            clr_r[0] <= 1'b0;
            state_r <= S_FP_ID;
          end
        end
      end
      if (state_r == S_FP_ID) begin
        clr_r[0] <= 1'b1;
        if (clr_r[0]) begin
          emit(ST_OK, 6'(g_q - 1'b1), t_id_q, '0);
          state_r <= S_IDLE;
        end
      end
      if (state_r == S_FI_RD) begin
        out_origin_x <= px_r;
        out_origin_y <= py_r;
        out_span_w <= pw_r;
        out_span_h <= ph_r;
        if (lo_r < hi_r) begin
          i_r <= mid;
          state_r <= S_FI_CMP;
        end else begin
          emit(ST_NOT_FOUND, '0, '0, '0);
          state_r <= S_IDLE;
        end
      end
      if (state_r == S_FI_CMP) begin
        state_r <= S_FI_RD;
        if (id_r < t_id_q) hi_r <= i_r;
        else if (id_r > t_id_q) lo_r <= i_r + 1'b1;
        else begin
          emit(ST_OK, 6'(i_r), t_id_q, '0);
          state_r <= S_IDLE;
        end
      end
    end
  end

  assign in_stall = (state_r != S_IDLE) || out_valid;
endmodule
`default_nettype wire

FILE: test/grid_position_index_unit_test.sv
`default_nettype none
module grid_position_index_unit_test;
  import gpi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 50;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  found_index;
    logic [15:0] found_id;
    logic [15:0] other_id;
    logic [7:0]  origin_x;
    logic [7:0]  origin_y;
    logic [8:0]  span_w;
    logic [8:0]  span_h;
  } grid_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [2:0] in_op;
  logic [15:0] in_entry_id;
  logic signed [7:0] in_pos_x;
  logic signed [7:0] in_pos_y;
  logic out_valid;
  logic out_stall;
  logic [2:0] out_status;
  logic [5:0] out_found_index;
  logic [15:0] out_found_id;
  logic [15:0] out_other_id;
  logic signed [7:0] out_origin_x;
  logic signed [7:0] out_origin_y;
  logic [8:0] out_span_w;
  logic [8:0] out_span_h;

  grid_position_index_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_entry_id(in_entry_id), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_found_index(out_found_index), .out_found_id(out_found_id),
    .out_other_id(out_other_id), .out_origin_x(out_origin_x),
    .out_origin_y(out_origin_y), .out_span_w(out_span_w), .out_span_h(out_span_h)
  );

  // predicted state of the index
  logic [15:0] table_ids [MAX_ENTRIES];
  logic signed [7:0] table_xs [MAX_ENTRIES];
  logic signed [7:0] table_ys [MAX_ENTRIES];
  int table_count;
  int cell_slots [GRID_CELLS];
  int plane_x, plane_y, plane_w, plane_h;
  bit plane_ok;

  grid_result_t pending_results[$];
  int error_count;
  int sender_idle_pct;
  int receiver_stall_pct;
  int stall_hold_cycles;
  int quiet_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic grid_result_t make_result(logic [2:0] status, int slot, int id, int other);
    grid_result_t r;
    r.status = status;
    r.found_index = slot[5:0];
    r.found_id = id[15:0];
    r.other_id = other[15:0];
    r.origin_x = plane_x[7:0];
    r.origin_y = plane_y[7:0];
    r.span_w = plane_w[8:0];
    r.span_h = plane_h[8:0];
    return r;
  endfunction

  function automatic grid_result_t predict_grid_op(logic [2:0] op, logic [15:0] id,
                                                   logic signed [7:0] x,
                                                   logic signed [7:0] y);
    int xi, yi, xlo, xhi, ylo, yhi, p, c, dx, dy, lo, hi, mid;
    xi = x;
    yi = y;
    case (op)
      OP_CLEAR: begin
        table_count = 0;
        plane_x = 0; plane_y = 0; plane_w = 0; plane_h = 0;
        plane_ok = 0;
        return make_result(ST_OK, 0, 0, 0);
      end
      OP_LOAD: begin
        if (table_count >= MAX_ENTRIES) return make_result(ST_FULL, 0, 0, 0);
        table_ids[table_count] = id;
        table_xs[table_count] = x;
        table_ys[table_count] = y;
        table_count++;
        return make_result(ST_OK, table_count - 1, id, 0);
      end
      OP_BUILD: begin
        plane_ok = 0;
        if (table_count == 0) begin
          plane_x = 0; plane_y = 0; plane_w = 0; plane_h = 0;
          return make_result(ST_EMPTY, 0, 0, 0);
        end
        xlo = table_xs[0]; xhi = xlo;
        ylo = table_ys[0]; yhi = ylo;
        for (int i = 1; i < table_count; i++) begin
          if (table_xs[i] < xlo) xlo = table_xs[i];
          if (table_xs[i] > xhi) xhi = table_xs[i];
          if (table_ys[i] < ylo) ylo = table_ys[i];
          if (table_ys[i] > yhi) yhi = table_ys[i];
        end
        plane_x = xlo; plane_y = ylo;
        plane_w = xhi - xlo + 1; plane_h = yhi - ylo + 1;
        if (plane_w * plane_h > GRID_CELLS) begin
          plane_w = 0; plane_h = 0;
          return make_result(ST_TOO_LARGE, 0, 0, 0);
        end
        for (int i = 0; i < GRID_CELLS; i++) cell_slots[i] = 0;
        for (int i = 0; i < table_count; i++) begin
          p = (table_ys[i] - plane_y) * plane_w + (table_xs[i] - plane_x);
          if (cell_slots[p] != 0)
            return make_result(ST_COLLISION, i, table_ids[i], table_ids[cell_slots[p] - 1]);
          cell_slots[p] = i + 1;
        end
        plane_ok = 1;
        return make_result(ST_OK, 0, 0, 0);
      end
      OP_FIND_POS: begin
        if (!plane_ok || xi < plane_x || yi < plane_y)
          return make_result(ST_NOT_FOUND, 0, 0, 0);
        dx = xi - plane_x;
        dy = yi - plane_y;
        if (dx >= plane_w || dy >= plane_h) return make_result(ST_NOT_FOUND, 0, 0, 0);
        c = cell_slots[dy * plane_w + dx];
        if (c == 0 || c > table_count) return make_result(ST_NOT_FOUND, 0, 0, 0);
        return make_result(ST_OK, c - 1, table_ids[c - 1], 0);
      end
      OP_FIND_ID: begin
        lo = 0;
        hi = table_count;
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          if (id < table_ids[mid]) hi = mid;
          else if (id > table_ids[mid]) lo = mid + 1;
          else return make_result(ST_OK, mid, table_ids[mid], 0);
        end
        return make_result(ST_NOT_FOUND, 0, 0, 0);
      end
      default: return make_result(ST_NOT_FOUND, 0, 0, 0);
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic send_item(logic [2:0] op, logic [15:0] id, logic signed [7:0] x,
                           logic signed [7:0] y);
    grid_result_t want;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_entry_id <= id;
    in_pos_x <= x;
    in_pos_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = predict_grid_op(op, id, x, y);
    pending_results.push_back(want);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  // receiver side, with an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_hold_cycles > 0) begin
      out_stall <= 1'b1;
      stall_hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    grid_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", out_status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_found_index !== want.found_index)
          report_mismatch("found_index", out_found_index, want.found_index);
        if (out_found_id !== want.found_id)
          report_mismatch("found_id", out_found_id, want.found_id);
        if (out_other_id !== want.other_id)
          report_mismatch("other_id", out_other_id, want.other_id);
        if (out_origin_x !== want.origin_x)
          report_mismatch("origin_x", out_origin_x, want.origin_x);
        if (out_origin_y !== want.origin_y)
          report_mismatch("origin_y", out_origin_y, want.origin_y);
        if (out_span_w !== want.span_w) report_mismatch("span_w", out_span_w, want.span_w);
        if (out_span_h !== want.span_h) report_mismatch("span_h", out_span_h, want.span_h);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_item(OP_CLEAR, 16'h0, 8'sd0, 8'sd0);
    send_item(OP_BUILD, 16'hffff, -8'sd128, 8'sd127);
    send_item(OP_FIND_POS, 16'h0, 8'sd0, 8'sd0);
    send_item(OP_FIND_ID, 16'h0, 8'sd0, 8'sd0);
    for (int k = 1; k <= 3; k++)
      send_item(OP_FIND_ID + 3'(k), 16'hffff, -8'sd128, 8'sd127);
    send_item(OP_LOAD, 16'h0000, -8'sd128, -8'sd128);
    send_item(OP_LOAD, 16'hffff, 8'sd127, 8'sd127);
    send_item(OP_BUILD, 16'h0, 8'sd0, 8'sd0);
    send_item(OP_FIND_POS, 16'h0, -8'sd128, -8'sd128);
    send_item(OP_CLEAR, 16'h0, 8'sd0, 8'sd0);
    send_item(OP_LOAD, 16'd10, 8'sd0, 8'sd0);
    send_item(OP_LOAD, 16'd20, 8'sd1, 8'sd0);
    send_item(OP_LOAD, 16'd30, 8'sd0, 8'sd1);
    send_item(OP_BUILD, 16'h0, 8'sd0, 8'sd0);
    send_item(OP_FIND_POS, 16'h0, 8'sd1, 8'sd0);
    send_item(OP_FIND_POS, 16'h0, 8'sd1, 8'sd1);
    send_item(OP_FIND_POS, 16'h0, 8'sd2, 8'sd0);
    send_item(OP_FIND_POS, 16'h0, -8'sd1, 8'sd0);
    send_item(OP_FIND_ID, 16'd30, 8'sd0, 8'sd0);
    send_item(OP_FIND_ID, 16'd25, 8'sd0, 8'sd0);
    send_item(OP_LOAD, 16'd40, 8'sd0, 8'sd0);
    send_item(OP_BUILD, 16'h0, 8'sd0, 8'sd0);
    send_item(OP_FIND_POS, 16'h0, 8'sd0, 8'sd0);
    wait_all_results();
  endtask

  // clears, loads a table (optionally with unsorted ids or shared cells), builds it and queries it
  task automatic run_table_sequence(int entries, bit sorted_ids, bit allow_collide);
    bit used [64];
    int box_w, box_h, ox, oy, cell_ix, id_step, id_val;
    logic signed [7:0] xs [MAX_ENTRIES];
    logic signed [7:0] ys [MAX_ENTRIES];
    logic [15:0] ids [MAX_ENTRIES];
    box_w = $urandom_range(8, 1);
    box_h = $urandom_range(8, 1);
    if (entries > box_w * box_h && !allow_collide) entries = box_w * box_h;
    ox = $urandom_range(255 - box_w + 1) - 128;
    oy = $urandom_range(255 - box_h + 1) - 128;
    foreach (used[i]) used[i] = 0;
    id_step = 65535 / (entries + 1);
    id_val = $urandom_range(id_step);
    send_item(OP_CLEAR, 16'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < entries; i++) begin
      do cell_ix = $urandom_range(box_w * box_h - 1);
      while (used[cell_ix] && !allow_collide);
      used[cell_ix] = 1;
      xs[i] = 8'(ox + cell_ix % box_w);
      ys[i] = 8'(oy + cell_ix / box_w);
      id_val += $urandom_range(id_step, 1);
      ids[i] = sorted_ids ? 16'(id_val) : 16'($urandom);
      send_item(OP_LOAD, ids[i], xs[i], ys[i]);
    end
    send_item(OP_BUILD, 16'($urandom), 8'($urandom), 8'($urandom));
    repeat ($urandom_range(12, 4)) begin
      cell_ix = $urandom_range(entries - 1);
      case ($urandom_range(3))
        0: send_item(OP_FIND_POS, 16'($urandom), xs[cell_ix], ys[cell_ix]);
        1: send_item(OP_FIND_POS, 16'($urandom), 8'(ox - 1 + $urandom_range(box_w + 1)),
                     8'(oy - 1 + $urandom_range(box_h + 1)));
        2: send_item(OP_FIND_ID, ids[cell_ix], 8'($urandom), 8'($urandom));
        default: send_item(OP_FIND_ID, 16'($urandom), 8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  task automatic test_full_table();
    run_table_sequence(MAX_ENTRIES, 1, 0);
    repeat (MAX_ENTRIES) send_item(OP_LOAD, 16'hffff, 8'sd127, -8'sd128);
    send_item(OP_FIND_ID, 16'hffff, 8'sd0, 8'sd0);
    wait_all_results();
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int items);
    int sent;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(9))
        0, 1: begin
          repeat (4) begin
            send_item(3'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
            sent++;
          end
        end
        2: begin
          run_table_sequence($urandom_range(20, 1), $urandom_range(1), 1);
          sent += 20;
        end
        default: begin
          run_table_sequence($urandom_range(20, 1), 1, 0);
          sent += 20;
        end
      endcase
    end
    wait_all_results();
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    stall_hold_cycles = 300;
    repeat (12) send_item(OP_FIND_ID, 16'($urandom), 8'($urandom), 8'($urandom));
    wait_all_results();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_CLEAR;
    in_entry_id = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    error_count = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    stall_hold_cycles = 0;
    quiet_cycles = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_backpressure();
    test_random_phase(0, 0, 130);
    test_random_phase(79, 0, 130);
    test_random_phase(0, 79, 130);
    test_random_phase(33, 33, 130);
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
sv/gpi_pkg.sv
sv/grid_position_index_unit.sv
test/grid_position_index_unit_test.sv
